// ----- sv/glpd_pkg.sv -----
// Shared types and constants of the GIF LZW pixel decoder.
`default_nettype none

package glpd_pkg;

   // default sizes of the code table
   localparam int DEF_MAX_CODE_BITS = 12;
   localparam int DEF_TABLE_DEPTH   = 4096;

   // fixed field widths
   localparam int CODE_W     = 12;   // code and prefix width
   localparam int BUF_W      = 20;   // bit unpacking buffer
   localparam int HELD_W     = 5;
   localparam int NFC_W      = 13;   // next free code, can reach 4096
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam int PIX_CNT_W  = 32;
   localparam int COORD_W    = 17;

   // push is refused when more than this many bits are held
   localparam logic [HELD_W-1:0] HELD_LIMIT = 5'd12;

   typedef enum logic [2:0] {
      K_TAKEN   = 3'd0,
      K_REFUSED = 3'd1,
      K_PIXEL   = 3'd2,
      K_NEED    = 3'd3,
      K_DONE    = 3'd4,
      K_ERROR   = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      E_NONE       = 2'd0,
      E_FIRST_CODE = 2'd1,
      E_COUNT      = 2'd2,
      E_AFTER_END  = 2'd3
   } err_type;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] R_MIN_CODE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] R_PALETTE_ENTRIES = 3'd1;
   localparam logic [CSR_IDX_W-1:0] R_TRANSP_ENABLE   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] R_TRANSP_INDEX    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] R_FRAME_LEFT      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] R_FRAME_TOP       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] R_FRAME_WIDTH     = 3'd6;
   localparam logic [CSR_IDX_W-1:0] R_FRAME_HEIGHT    = 3'd7;

   // one string table entry
   typedef struct packed {
      logic [CODE_W-1:0] prefix;
      logic [7:0]        suffix;
      logic [7:0]        first;
   } entry_type;

   // one response
   typedef struct packed {
      kind_type           kind;
      logic [7:0]         pixel_index;
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic               is_transparent;
      err_type            error_code;
   } res_type;

endpackage

`default_nettype wire

// ----- sv/glpd_if.sv -----
// Request and response channel interfaces of the GIF LZW pixel decoder.
`default_nettype none

interface glpd_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [7:0] data_byte;

   modport source (output valid, action, data_byte, input ready);
   modport sink   (input valid, action, data_byte, output ready);
endinterface

interface glpd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [7:0]  pixel_index;
   logic [16:0] pixel_x;
   logic [16:0] pixel_y;
   logic        is_transparent;
   logic [1:0]  error_code;

   modport source (output valid, kind, pixel_index, pixel_x, pixel_y, is_transparent,
                   error_code, input ready);
   modport sink   (input valid, kind, pixel_index, pixel_x, pixel_y, is_transparent,
                   error_code, output ready);
endinterface

`default_nettype wire

// ----- sv/glpd_table.sv -----
// String table memory: prefix, suffix and first character per code.
`default_nettype none

module glpd_table #(
   parameter int TABLE_DEPTH = glpd_pkg::DEF_TABLE_DEPTH
) (
   input  wire logic                           clock,
   input  wire logic                           we,
   input  wire logic [$clog2(TABLE_DEPTH)-1:0] waddr,
   input  wire glpd_pkg::entry_type            wdata,
   input  wire logic [$clog2(TABLE_DEPTH)-1:0] raddr,
   output glpd_pkg::entry_type                 rdata
);
   import glpd_pkg::*;

   entry_type mem [TABLE_DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

// ----- sv/glpd_stack.sv -----
// String stack memory holding decoded color indices.
`default_nettype none

module glpd_stack #(
   parameter int TABLE_DEPTH = glpd_pkg::DEF_TABLE_DEPTH
) (
   input  wire logic                           clock,
   input  wire logic                           we,
   input  wire logic [$clog2(TABLE_DEPTH)-1:0] waddr,
   input  wire logic [7:0]                     wdata,
   input  wire logic [$clog2(TABLE_DEPTH)-1:0] raddr,
   output logic [7:0]                          rdata
);
   logic [7:0] mem [TABLE_DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

`default_nettype wire

// ----- sv/gif_lzw_pixel_decoder.sv -----
// Push request: answer is registered, via the hold register if the output stalls.
// Pull with pixels stacked: stack read in S_POP, then the pixel answer is registered.
// Pull that must decode: codes read from the bit buffer, characters walked in the table
// memory, then pops. Rate is set by the prefix walk: one table read per character.
// Reset is synchronous: control and configuration return to defaults; the table and
// stack memories are not cleared, since entries are always written before being read.
`default_nettype none

module gif_lzw_pixel_decoder #(
   parameter int MAX_CODE_BITS = glpd_pkg::DEF_MAX_CODE_BITS,
   parameter int TABLE_DEPTH   = glpd_pkg::DEF_TABLE_DEPTH
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   glpd_req_if.sink                                req_ch,
   glpd_rsp_if.source                              rsp_ch,
   input  wire logic                               csr_we,
   input  wire logic [glpd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [glpd_pkg::CSR_DATA_W-1:0]    csr_data
);
   import glpd_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam logic [NFC_W-1:0] DEPTH_N  = NFC_W'(TABLE_DEPTH);
   localparam logic [AW:0]      DEPTH_S  = (AW+1)'(TABLE_DEPTH);
   localparam logic [3:0]       MAX_W    = 4'(MAX_CODE_BITS);

   typedef enum logic [2:0] {
      S_IDLE, S_DECODE, S_WALK, S_ROOT, S_CHECK, S_POP, S_HOLD
   } state_type;

   // registers
   state_type            state_ff, state_in;
   logic [BUF_W-1:0]     buf_ff, buf_in;
   logic [HELD_W-1:0]    held_ff, held_in;
   logic [3:0]           cw_ff, cw_in;
   logic [NFC_W-1:0]     nf_ff, nf_in;
   logic [CODE_W-1:0]    prev_ff, prev_in;
   logic [7:0]           prev_first_ff, prev_first_in;
   logic                 after_clear_ff, after_clear_in;
   logic                 finished_ff, finished_in;
   logic [AW:0]          depth_ff, depth_in;
   logic [15:0]          col_ff, col_in;
   logic [COORD_W-1:0]   row_ff, row_in;
   logic [PIX_CNT_W-1:0] pix_ff, pix_in;
   logic [CODE_W-1:0]    cur_code_ff, cur_code_in;
   logic [CODE_W-1:0]    walk_ff, walk_in;
   logic                 first_ff, first_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   res_type              rsp_ff, rsp_in;
   res_type              pend_ff, pend_in;
   // configuration
   logic [3:0]           min_cw_ff, min_cw_in;
   logic [8:0]           pal_ff, pal_in;
   logic                 te_ff, te_in;
   logic [7:0]           ti_ff, ti_in;
   logic [15:0]          left_ff, left_in;
   logic [15:0]          top_ff, top_in;
   logic [15:0]          width_ff, width_in;
   logic [15:0]          height_ff, height_in;

   // memory ports
   logic          tbl_we;
   logic [AW-1:0] tbl_waddr, tbl_raddr;
   entry_type     tbl_wdata, tbl_rdata;
   logic          stk_we;
   logic [AW-1:0] stk_waddr, stk_raddr;
   logic [7:0]    stk_wdata, stk_rdata;

   glpd_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table (
      .clock (clock),
      .we    (tbl_we),
      .waddr (tbl_waddr),
      .wdata (tbl_wdata),
      .raddr (tbl_raddr),
      .rdata (tbl_rdata)
   );

   glpd_stack #(.TABLE_DEPTH(TABLE_DEPTH)) u_stack (
      .clock (clock),
      .we    (stk_we),
      .waddr (stk_waddr),
      .wdata (stk_wdata),
      .raddr (stk_raddr),
      .rdata (stk_rdata)
   );

   // derived code values
   logic [3:0]        eff_min;
   logic [NFC_W-1:0]  clear_n;
   logic [CODE_W-1:0] code_mask;
   logic [CODE_W-1:0] code;
   logic [NFC_W-1:0]  code_n;
   logic [PIX_CNT_W-1:0] area;
   logic              slot_free;
   logic              req_acc;

   always_comb begin
      if (min_cw_ff < 4'd2) begin
         eff_min = 4'd2;
      end else if (min_cw_ff > 4'd8) begin
         eff_min = 4'd8;
      end else begin
         eff_min = min_cw_ff;
      end
   end

   assign clear_n   = NFC_W'(1) << eff_min;
   assign code_mask = CODE_W'((NFC_W'(1) << cw_ff) - NFC_W'(1));
   assign code      = buf_ff[CODE_W-1:0] & code_mask;
   assign code_n    = {1'b0, code};
   assign area      = PIX_CNT_W'(width_ff) * PIX_CNT_W'(height_ff);
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_acc   = req_ch.valid && req_ch.ready;

   assign req_ch.ready = (state_ff == S_IDLE);

   // decoder control
   logic             push_req;
   logic [7:0]       push_ch;
   logic             entry_req;
   logic [7:0]       entry_suffix;
   logic             res_req;
   res_type          res;
   logic [NFC_W-1:0] c_n;
   logic [NFC_W-1:0] nf_next;
   logic [16:0]      col_next;

   always_comb begin
      state_in       = state_ff;
      buf_in         = buf_ff;
      held_in        = held_ff;
      cw_in          = cw_ff;
      nf_in          = nf_ff;
      prev_in        = prev_ff;
      prev_first_in  = prev_first_ff;
      after_clear_in = after_clear_ff;
      finished_in    = finished_ff;
      depth_in       = depth_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      pix_in         = pix_ff;
      cur_code_in    = cur_code_ff;
      walk_in        = walk_ff;
      first_in       = first_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;
      rsp_in         = rsp_ff;
      pend_in        = pend_ff;
      min_cw_in      = min_cw_ff;
      pal_in         = pal_ff;
      te_in          = te_ff;
      ti_in          = ti_ff;
      left_in        = left_ff;
      top_in         = top_ff;
      width_in       = width_ff;
      height_in      = height_ff;
      tbl_we         = 1'b0;
      tbl_waddr      = nf_ff[AW-1:0];
      tbl_wdata      = '{prefix: prev_ff, suffix: 8'd0, first: prev_first_ff};
      tbl_raddr      = code[AW-1:0];
      stk_we         = 1'b0;
      stk_waddr      = depth_ff[AW-1:0];
      stk_wdata      = 8'd0;
      stk_raddr      = AW'(depth_ff - (AW+1)'(1));
      push_req       = 1'b0;
      push_ch        = 8'd0;
      entry_req      = 1'b0;
      entry_suffix   = 8'd0;
      res_req        = 1'b0;
      res            = '{kind: K_TAKEN, pixel_index: 8'd0, pixel_x: '0, pixel_y: '0,
                         is_transparent: 1'b0, error_code: E_NONE};
      c_n            = {1'b0, tbl_rdata.prefix};
      nf_next        = nf_ff + NFC_W'(1);
      col_next       = {1'b0, col_ff} + 17'd1;

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (finished_ff) begin
                  res_req        = 1'b1;
                  res.kind       = K_ERROR;
                  res.error_code = E_AFTER_END;
               end else if (!req_ch.action) begin
                  res_req = 1'b1;
                  if (held_ff > HELD_LIMIT) begin
                     res.kind = K_REFUSED;
                  end else begin
                     buf_in  = buf_ff | (BUF_W'(req_ch.data_byte) << held_ff);
                     held_in = held_ff + HELD_W'(8);
                     res.kind = K_TAKEN;
                  end
               end else if (depth_ff != '0) begin
                  depth_in = depth_ff - (AW+1)'(1);
                  state_in = S_POP;
               end else begin
                  state_in = S_DECODE;
               end
            end
         end

         S_DECODE: begin
            if (held_ff < {1'b0, cw_ff}) begin
               res_req  = 1'b1;
               res.kind = K_NEED;
            end else begin
               buf_in  = buf_ff >> cw_ff;
               held_in = held_ff - {1'b0, cw_ff};
               if (code_n == clear_n) begin
                  // clear code: restart the table
                  nf_in          = clear_n + NFC_W'(2);
                  cw_in          = eff_min + 4'd1;
                  after_clear_in = 1'b1;
               end else if (code_n == clear_n + NFC_W'(1)) begin
                  // end code: check pixel count
                  finished_in = 1'b1;
                  res_req     = 1'b1;
                  if (pix_ff == area) begin
                     res.kind = K_DONE;
                  end else begin
                     res.kind       = K_ERROR;
                     res.error_code = E_COUNT;
                  end
               end else if (after_clear_ff) begin
                  if (code_n > clear_n) begin
                     finished_in    = 1'b1;
                     res_req        = 1'b1;
                     res.kind       = K_ERROR;
                     res.error_code = E_FIRST_CODE;
                  end else begin
                     push_req       = 1'b1;
                     push_ch        = code[7:0];
                     prev_in        = code;
                     prev_first_in  = code[7:0];
                     after_clear_in = 1'b0;
                     state_in       = S_CHECK;
                  end
               end else if (code_n < nf_ff) begin
                  if (code_n < clear_n) begin
                     // root code
                     push_req      = 1'b1;
                     push_ch       = code[7:0];
                     entry_req     = 1'b1;
                     entry_suffix  = code[7:0];
                     prev_in       = code;
                     prev_first_in = code[7:0];
                     state_in      = S_CHECK;
                  end else begin
                     // known string: walk its chain, entry added on first read
                     tbl_raddr   = code[AW-1:0];
                     cur_code_in = code;
                     first_in    = 1'b1;
                     state_in    = S_WALK;
                  end
               end else begin
                  // KwKwK: previous string plus its first character
                  push_req = 1'b1;
                  push_ch  = prev_first_ff;
                  if (nf_ff < DEPTH_N) begin
                     entry_req    = 1'b1;
                     entry_suffix = prev_first_ff;
                     prev_in      = nf_ff[CODE_W-1:0];
                  end
                  first_in = 1'b0;
                  if ({1'b0, prev_ff} >= clear_n) begin
                     tbl_raddr = prev_ff[AW-1:0];
                     state_in  = S_WALK;
                  end else begin
                     walk_in  = prev_ff;
                     state_in = S_ROOT;
                  end
               end
            end
         end

         S_WALK: begin
            if (first_ff) begin
               entry_req     = 1'b1;
               entry_suffix  = tbl_rdata.first;
               prev_in       = cur_code_ff;
               prev_first_in = tbl_rdata.first;
            end
            first_in = 1'b0;
            push_req = 1'b1;
            push_ch  = tbl_rdata.suffix;
            if (c_n >= clear_n && c_n < DEPTH_N) begin
               tbl_raddr = tbl_rdata.prefix[AW-1:0];
            end else begin
               walk_in  = tbl_rdata.prefix;
               state_in = S_ROOT;
            end
         end

         S_ROOT: begin
            if ({1'b0, walk_ff} < clear_n) begin
               push_req = 1'b1;
               push_ch  = walk_ff[7:0];
            end
            state_in = S_CHECK;
         end

         S_CHECK: begin
            if (depth_ff != '0) begin
               depth_in = depth_ff - (AW+1)'(1);
               state_in = S_POP;
            end else begin
               state_in = S_DECODE;
            end
         end

         S_POP: begin
            res_req            = 1'b1;
            res.kind           = K_PIXEL;
            res.pixel_index    = stk_rdata;
            res.pixel_x        = {1'b0, left_ff} + {1'b0, col_ff};
            res.pixel_y        = row_ff;
            res.is_transparent = te_ff && (stk_rdata == ti_ff);
            if (col_next >= {1'b0, width_ff}) begin
               col_in = 16'd0;
               row_in = row_ff + COORD_W'(1);
            end else begin
               col_in = col_next[15:0];
            end
            pix_in = pix_ff + PIX_CNT_W'(1);
         end

         S_HOLD: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = pend_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // stack push of one character
      if (push_req && ({1'b0, push_ch} < pal_ff) && (depth_ff < DEPTH_S)) begin
         stk_we    = 1'b1;
         stk_wdata = push_ch;
         depth_in  = depth_ff + (AW+1)'(1);
      end

      // table entry add and code width growth
      if (entry_req && (nf_ff < DEPTH_N)) begin
         tbl_we           = 1'b1;
         tbl_wdata.suffix = entry_suffix;
         nf_in            = nf_next;
         if (nf_next == (NFC_W'(1) << cw_ff) && cw_ff < MAX_W) begin
            cw_in = cw_ff + 4'd1;
         end
      end

      // result goes out directly or waits in the hold register
      if (res_req) begin
         if (slot_free) begin
            rsp_valid_in = 1'b1;
            rsp_in       = res;
            state_in     = S_IDLE;
         end else begin
            pend_in  = res;
            state_in = S_HOLD;
         end
      end

      // configuration writes
      if (csr_we) begin
         case (csr_index)
            R_MIN_CODE_WIDTH: begin
               min_cw_in = csr_data[3:0];
               if (csr_data[3:0] < 4'd2) begin
                  nf_in = NFC_W'(1) << 2;
                  cw_in = 4'd3;
               end else if (csr_data[3:0] > 4'd8) begin
                  nf_in = NFC_W'(1) << 8;
                  cw_in = 4'd9;
               end else begin
                  nf_in = NFC_W'(1) << csr_data[3:0];
                  cw_in = csr_data[3:0] + 4'd1;
               end
               nf_in          = nf_in + NFC_W'(2);
               after_clear_in = 1'b1;
            end
            R_PALETTE_ENTRIES: pal_in    = csr_data[8:0];
            R_TRANSP_ENABLE:   te_in     = csr_data[0];
            R_TRANSP_INDEX:    ti_in     = csr_data[7:0];
            R_FRAME_LEFT:      left_in   = csr_data;
            R_FRAME_TOP: begin
               top_in = csr_data;
               row_in = {1'b0, csr_data};
            end
            R_FRAME_WIDTH:     width_in  = csr_data;
            R_FRAME_HEIGHT:    height_in = csr_data;
            default: begin
            end
         endcase
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         buf_ff         <= '0;
         held_ff        <= '0;
         cw_ff          <= 4'd9;
         nf_ff          <= NFC_W'(258);
         prev_ff        <= '0;
         prev_first_ff  <= '0;
         after_clear_ff <= 1'b1;
         finished_ff    <= 1'b0;
         depth_ff       <= '0;
         col_ff         <= '0;
         row_ff         <= '0;
         pix_ff         <= '0;
         first_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         min_cw_ff      <= 4'd8;
         pal_ff         <= 9'd256;
         te_ff          <= 1'b0;
         ti_ff          <= '0;
         left_ff        <= '0;
         top_ff         <= '0;
         width_ff       <= 16'd1;
         height_ff      <= '0;
      end else begin
         state_ff       <= state_in;
         buf_ff         <= buf_in;
         held_ff        <= held_in;
         cw_ff          <= cw_in;
         nf_ff          <= nf_in;
         prev_ff        <= prev_in;
         prev_first_ff  <= prev_first_in;
         after_clear_ff <= after_clear_in;
         finished_ff    <= finished_in;
         depth_ff       <= depth_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         pix_ff         <= pix_in;
         first_ff       <= first_in;
         rsp_valid_ff   <= rsp_valid_in;
         min_cw_ff      <= min_cw_in;
         pal_ff         <= pal_in;
         te_ff          <= te_in;
         ti_ff          <= ti_in;
         left_ff        <= left_in;
         top_ff         <= top_in;
         width_ff       <= width_in;
         height_ff      <= height_in;
      end
      rsp_ff      <= rsp_in;
      pend_ff     <= pend_in;
      cur_code_ff <= cur_code_in;
      walk_ff     <= walk_in;
   end

   // response port
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.kind           = rsp_ff.kind;
   assign rsp_ch.pixel_index    = rsp_ff.pixel_index;
   assign rsp_ch.pixel_x        = rsp_ff.pixel_x;
   assign rsp_ch.pixel_y        = rsp_ff.pixel_y;
   assign rsp_ch.is_transparent = rsp_ff.is_transparent;
   assign rsp_ch.error_code     = rsp_ff.error_code;

   // checks
   a_depth_bound: assert property (@(posedge clock) disable iff (reset)
      depth_ff <= DEPTH_S) else $error("stack depth past capacity");

   a_width_bound: assert property (@(posedge clock) disable iff (reset)
      cw_ff <= MAX_W) else $error("code width past maximum");

   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff <= HELD_W'(BUF_W)) else $error("bit buffer overfilled");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK && depth_ff == '0) |=> state_ff != S_POP)
      else $error("pop from empty stack");

   a_hold_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HOLD) |-> rsp_valid_ff) else $error("hold without pending response");

endmodule

`default_nettype wire
